FILE: src/vtdc_pkg.sv
`timescale 1ns / 1ps
// Package for the vertex transform, divide and clip block.
// Holds the shared Q8.8 widths, the register index codes and the divider stage record.
package vtdc_pkg;

  localparam int unsigned QW    = 16;  // Q8.8 coordinate width
  localparam int unsigned CW    = 64;  // configuration data width
  localparam int unsigned QBITS = 24;  // quotient bits of the divide
  localparam int unsigned NDIM  = 4;
  localparam int unsigned IDXW  = 3;

  localparam logic [QW-1:0] Q_ONE = 16'sd256;

  typedef enum logic [IDXW-1:0] {
    CFG_ROW0      = 3'd0,
    CFG_ROW1      = 3'd1,
    CFG_ROW2      = 3'd2,
    CFG_ROW3      = 3'd3,
    CFG_CLIP_LOW  = 3'd4,
    CFG_CLIP_HIGH = 3'd5
  } cfg_idx_e;

  // One stage of the divide pipeline. The three lanes share the divisor.
  typedef struct packed {
    logic [2:0][QBITS-1:0] rq;    // dividend bits shifting out, quotient bits shifting in
    logic [2:0][QW-1:0]    rem;   // partial remainder
    logic [QW-1:0]         dmag;  // divisor magnitude
    logic [2:0]            neg;   // quotient sign per lane
    logic                  wzero; // transformed w is zero: no divide
    logic [NDIM-1:0][QW-1:0] t;   // transformed vector
  } div_stage_t;

endpackage

FILE: src/vtdc_xform.sv
`timescale 1ns / 1ps
// Matrix-vector transform: products, row sums, truncation and saturation in three stages.
// Depends on vtdc_pkg.
module vtdc_xform (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [vtdc_pkg::NDIM-1:0][vtdc_pkg::QW-1:0] v_i,
  input  logic [vtdc_pkg::NDIM-1:0][vtdc_pkg::CW-1:0] rows_i,
  output logic                                       valid_o,
  output logic [vtdc_pkg::NDIM-1:0][vtdc_pkg::QW-1:0] t_o
);
  import vtdc_pkg::*;

  logic [NDIM-1:0][NDIM-1:0][2*QW-1:0] prod_d, prod_q;
  logic [NDIM-1:0][2*QW+1:0]           sum_d, sum_q;
  logic [NDIM-1:0][QW-1:0]             t_d, t_q;
  logic [2:0]                          vld_q;

  always_comb begin
    for (int r = 0; r < NDIM; r++) begin
      for (int c = 0; c < NDIM; c++) begin
        prod_d[r][c] = $signed(rows_i[r][QW*c +: QW]) * $signed(v_i[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NDIM; r++) begin
      sum_d[r] = (2*QW+2)'($signed(prod_q[r][0])) + (2*QW+2)'($signed(prod_q[r][1]))
               + (2*QW+2)'($signed(prod_q[r][2])) + (2*QW+2)'($signed(prod_q[r][3]));
    end
  end

  // Divide by 256 toward zero: bias negative sums before the arithmetic shift.
  always_comb begin
    logic signed [2*QW+1:0] adj;
    logic signed [2*QW+1:0] shr;
    for (int r = 0; r < NDIM; r++) begin
      adj = $signed(sum_q[r]) + (sum_q[r][2*QW+1] ? 34'sd255 : 34'sd0);
      shr = adj >>> 8;
      if (shr > 34'sd32767) begin
        t_d[r] = 16'h7fff;
      end else if (shr < -34'sd32768) begin
        t_d[r] = 16'h8000;
      end else begin
        t_d[r] = shr[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      t_q    <= t_d;
    end
  end

  assign valid_o = vld_q[2];
  assign t_o     = t_q;

endmodule

FILE: src/vtdc_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: x, y and z times 256 over w, one quotient bit per stage.
// Depends on vtdc_pkg.
module vtdc_divider (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [vtdc_pkg::NDIM-1:0][vtdc_pkg::QW-1:0] t_i,
  output logic                                       valid_o,
  output vtdc_pkg::div_stage_t                       stage_o
);
  import vtdc_pkg::*;

  div_stage_t           st_q [QBITS+1];
  div_stage_t           st_d [QBITS+1];
  logic [QBITS:0]       vld_q;

  // Setup stage: magnitudes and signs.
  always_comb begin
    logic [QW-1:0] mag;
    st_d[0]       = '0;
    st_d[0].t     = t_i;
    st_d[0].wzero = (t_i[3] == '0);
    st_d[0].dmag  = t_i[3][QW-1] ? (~t_i[3] + 16'd1) : t_i[3];
    for (int l = 0; l < 3; l++) begin
      mag             = t_i[l][QW-1] ? (~t_i[l] + 16'd1) : t_i[l];
      st_d[0].neg[l]  = t_i[l][QW-1] ^ t_i[3][QW-1];
      st_d[0].rq[l]   = {mag, 8'h00};
      st_d[0].rem[l]  = '0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    always_comb begin
      logic [QW:0] rs;
      logic [QW:0] diff;
      logic        ge;
      st_d[k+1] = st_q[k];
      for (int l = 0; l < 3; l++) begin
        rs   = {st_q[k].rem[l], st_q[k].rq[l][QBITS-1]};
        diff = rs - {1'b0, st_q[k].dmag};
        ge   = (rs >= {1'b0, st_q[k].dmag});
        st_d[k+1].rem[l] = ge ? diff[QW-1:0] : rs[QW-1:0];
        st_d[k+1].rq[l]  = {st_q[k].rq[l][QBITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QBITS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QBITS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[QBITS];
  assign stage_o = st_q[QBITS];

endmodule

FILE: src/vertex_transform_divide_clip.sv
`timescale 1ns / 1ps
// Top level: configuration registers, transform, divide pipeline and output register.
// Depends on vtdc_pkg, vtdc_xform and vtdc_divider.
//
//   channel | valid       | stall       | payload
//   input   | in_valid_i  | in_stall_o  | vx_i vy_i vz_i vw_i
//   output  | out_valid_o | out_stall_i | ox_o oy_o oz_o ow_o inside_res_o
//
// One vertex enters per cycle while in_stall_o is low; the pipeline has 3 transform stages,
// one divide setup stage, 24 divide stages with one quotient bit each and one output register.
// Reset loads the identity matrix and clip limits of -1.0 and 1.0.
// A stalled result freezes the whole pipeline, so in_stall_o follows out_stall_i
// while a result is waiting.
module vertex_transform_divide_clip (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vtdc_pkg::IDXW-1:0]  cfg_idx_i,
  input  logic [vtdc_pkg::CW-1:0]    cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [15:0]         vx_i,
  input  logic signed [15:0]         vy_i,
  input  logic signed [15:0]         vz_i,
  input  logic signed [15:0]         vw_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         ox_o,
  output logic signed [15:0]         oy_o,
  output logic signed [15:0]         oz_o,
  output logic signed [15:0]         ow_o,
  output logic                       inside_res_o
);
  import vtdc_pkg::*;

  logic [NDIM-1:0][CW-1:0] rows_q;
  logic [QW-1:0]           clip_lo_q, clip_hi_q;
  logic                    en;
  logic                    xf_valid, dv_valid;
  logic [NDIM-1:0][QW-1:0] v_in, xf_t;
  div_stage_t              dv;
  logic                    out_valid_q;
  logic [NDIM-1:0][QW-1:0] res_d, res_q;
  logic                    inside_d, inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NDIM; r++) begin
        rows_q[r] <= CW'(Q_ONE) << (QW*r);
      end
      clip_lo_q <= -Q_ONE;
      clip_hi_q <= Q_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW0:      rows_q[0] <= cfg_data_i;
        CFG_ROW1:      rows_q[1] <= cfg_data_i;
        CFG_ROW2:      rows_q[2] <= cfg_data_i;
        CFG_ROW3:      rows_q[3] <= cfg_data_i;
        CFG_CLIP_LOW:  clip_lo_q <= cfg_data_i[QW-1:0];
        CFG_CLIP_HIGH: clip_hi_q <= cfg_data_i[QW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign v_in       = {vw_i, vz_i, vy_i, vx_i};

  vtdc_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .v_i     (v_in),
    .rows_i  (rows_q),
    .valid_o (xf_valid),
    .t_o     (xf_t)
  );

  vtdc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xf_valid),
    .t_i     (xf_t),
    .valid_o (dv_valid),
    .stage_o (dv)
  );

  // Sign and saturate quotients (pass t on if w is zero), then test the clip window.
  always_comb begin
    logic [QBITS-1:0] q;
    logic [QW-1:0]    s;
    inside_d = 1'b1;
    for (int l = 0; l < 3; l++) begin
      q = dv.rq[l];
      if (dv.neg[l]) begin
        s = (q > 24'd32768) ? 16'h8000 : (~q[QW-1:0] + 16'd1);
      end else begin
        s = (q > 24'd32767) ? 16'h7fff : q[QW-1:0];
      end
      res_d[l] = dv.wzero ? dv.t[l] : s;
      if (($signed(res_d[l]) < $signed(clip_lo_q)) ||
          ($signed(res_d[l]) > $signed(clip_hi_q))) begin
        inside_d = 1'b0;
      end
    end
    res_d[3] = dv.wzero ? dv.t[3] : Q_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && dv_valid) begin
      res_q    <= res_d;
      inside_q <= inside_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ox_o         = res_q[0];
  assign oy_o         = res_q[1];
  assign oz_o         = res_q[2];
  assign ow_o         = res_q[3];
  assign inside_res_o = inside_q;

endmodule
